### hw/rtl/zsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbp_pkg
// Shared types and constants of the segment baseline parser.
// ----------------------------------------------------------------------------
package zsbp_pkg;

	localparam int OFFSET_W = 23;
	localparam int LENGTH_W = 22;
	localparam int COUNT_W  = 21;
	localparam int Q_W      = 24;
	localparam int SMP_W    = 16;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 23'h7FFFFF;
	localparam logic [SMP_W-1:0]    HALF_MASK    = 16'hFFFF;
	localparam int                  GOOD_BIT     = 31;

	localparam logic [OFFSET_W-1:0] TRACE_RESET  = 23'd16384;
	localparam logic [6:0]          BASE_RESET   = 7'd32;

	// configuration register indexes
	localparam logic [0:0] REG_TRACE_SAMPLES    = 1'd0;
	localparam logic [0:0] REG_BASELINE_SAMPLES = 1'd1;

	typedef struct packed {
		logic [31:0] data_word;
		logic        record_start;
	} item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] segment_offset;
		logic [LENGTH_W-1:0] segment_length;
		logic [Q_W-1:0]      baseline_mean;
		logic [Q_W-1:0]      baseline_deviation;
		logic                status;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FIN  = 5'b00010,
		ST_WALK = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

### hw/rtl/zle_segment_baseline_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zle_segment_baseline_parser
// Parses zero-length-encoded channel records and reports, for every good
// segment, its offset, length and baseline mean and deviation in Q16.8.
//
// item channel: one 32-bit record word per beat; record_start marks the size
// header that restarts the parse. result channel: one beat per good segment,
// sent after its last data word (at once for an empty segment).
// The block takes header, skip and data words back to back while idle. The
// word that ends a segment then occupies the block for a decision step, a
// serial division and the load of the output register. A short first
// segment adds reads from the sample memory before the division; an
// error or an inherited baseline skips both.
// The result sits in an output register: while the receiver stalls, the
// block keeps taking words until the next segment end must be loaded.
// Reset clears the parse state and restores trace_samples to 16384 and
// baseline_samples to 32; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
module zle_segment_baseline_parser #(
	parameter int MAX_BASELINE = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [22:0]              cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  zsbp_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output zsbp_pkg::result_t        result
);

	localparam int NW  = $clog2(MAX_BASELINE + 1);
	localparam int SW  = zsbp_pkg::SMP_W + NW;
	localparam int AW  = $clog2(MAX_BASELINE);
	localparam int OW  = zsbp_pkg::OFFSET_W;
	localparam int LW  = zsbp_pkg::LENGTH_W;
	localparam int CTW = zsbp_pkg::COUNT_W;
	localparam int QW  = zsbp_pkg::Q_W;
	localparam int PW  = zsbp_pkg::SMP_W;

	zsbp_pkg::state_t state_q;

	logic [OW-1:0]  trace_q, offset_q, prev_end_q;
	logic [6:0]     baseline_q;
	logic [CTW-1:0] words_left_q, pidx_q;
	logic [1:0]     seg_cnt_q;
	logic [SW-1:0]  run_sum_q;
	logic [PW-1:0]  run_lo_q, run_hi_q;
	logic [QW-1:0]  last_mean_q, last_dev_q, res_mean_q, res_dev_q;
	logic           failed_q, res_status_q;
	logic [LW-1:0]  seg_len_q;
	logic [AW-1:0]  walk_addr_q;
	logic [NW-1:0]  walk_left_q;
	logic           rd_pend_s1;
	logic           result_valid_q;
	zsbp_pkg::result_t result_q;

	logic [NW-1:0]  n_eff;
	logic           accept, data_beat, in_base, store_we, load_out;
	logic [31:0]    acc_word, rdata;
	logic [PW-1:0]  a, b, lo_ab, hi_ab;
	logic [SW-1:0]  sum_next;
	logic [PW-1:0]  lo_next, hi_next;
	logic [CTW-1:0] count;
	logic [LW-1:0]  len_ctl;
	logic [OW:0]    skip_sum, end_sum;
	logic [OW-1:0]  skip_sat, end_sat;
	logic [LW-1:0]  n_ext, n2_ext, walk_first;
	logic           walk_issue, stats_start, stats_done;
	logic [QW-1:0]  stats_mean, stats_dev;

	always_comb begin
		int nb;
		nb = int'(baseline_q);
		if (nb < 2) begin
			nb = 2;
		end else if (nb > MAX_BASELINE) begin
			nb = MAX_BASELINE;
		end
		n_eff = NW'(nb & ~1);
	end

	assign accept    = item_valid && !item_stall;
	assign data_beat = accept && !item.record_start && (words_left_q != '0);
	assign in_base   = pidx_q < CTW'(n_eff >> 1);
	assign store_we  = data_beat && (pidx_q < CTW'(MAX_BASELINE));

	// samples come from the item in idle, from the store during the walk
	assign acc_word = (state_q == zsbp_pkg::ST_WALK) ? rdata : item.data_word;
	assign a        = acc_word[PW-1:0];
	assign b        = acc_word[31:PW];

	always_comb begin
		lo_ab    = (a < b) ? a : b;
		hi_ab    = (a > b) ? a : b;
		sum_next = run_sum_q + SW'(a) + SW'(b);
		lo_next  = (lo_ab < run_lo_q) ? lo_ab : run_lo_q;
		hi_next  = (hi_ab > run_hi_q) ? hi_ab : run_hi_q;
	end

	assign count    = item.data_word[CTW-1:0];
	assign len_ctl  = {count, 1'b0};
	assign skip_sum = {1'b0, offset_q} + (OW + 1)'(len_ctl);
	assign skip_sat = (skip_sum > {1'b0, zsbp_pkg::OFFSET_MAX}) ?
		zsbp_pkg::OFFSET_MAX : skip_sum[OW-1:0];
	assign end_sum  = {1'b0, offset_q} + (OW + 1)'(seg_len_q);
	assign end_sat  = (end_sum > {1'b0, zsbp_pkg::OFFSET_MAX}) ?
		zsbp_pkg::OFFSET_MAX : end_sum[OW-1:0];

	assign n_ext      = LW'(n_eff);
	assign n2_ext     = LW'({n_eff, 1'b0});
	assign walk_first = (seg_len_q - n_ext) >> 1;
	assign walk_issue = (state_q == zsbp_pkg::ST_WALK) && (walk_left_q != '0);

	logic fin_stats;
	assign fin_stats = (state_q == zsbp_pkg::ST_FIN) && !failed_q &&
		!((seg_cnt_q != 2'd0) && (offset_q == prev_end_q)) && !(seg_len_q < n_ext) &&
		!((seg_len_q < n2_ext) && (end_sat < trace_q));
	assign stats_start = fin_stats || ((state_q == zsbp_pkg::ST_WALK) &&
		(walk_left_q == '0) && !rd_pend_s1);

	assign load_out = (state_q == zsbp_pkg::ST_DONE) && (!result_valid_q || !result_stall);

	// the store is only read while no item is taken, so writes and reads never meet
	zsbp_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BASELINE)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(pidx_q[AW-1:0]),
		.wdata(item.data_word),
		.raddr(walk_addr_q),
		.rdata(rdata)
	);

	zsbp_stats #(
		.N_W  (NW),
		.SUM_W(SW)
	) u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.start (stats_start),
		.sum   (run_sum_q),
		.lo    (run_lo_q),
		.hi    (run_hi_q),
		.n     (n_eff),
		.done  (stats_done),
		.mean  (stats_mean),
		.dev   (stats_dev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= zsbp_pkg::ST_IDLE;
			trace_q        <= zsbp_pkg::TRACE_RESET;
			baseline_q     <= zsbp_pkg::BASE_RESET;
			offset_q       <= '0;
			words_left_q   <= '0;
			prev_end_q     <= zsbp_pkg::OFFSET_MAX;
			seg_cnt_q      <= '0;
			run_sum_q      <= '0;
			run_lo_q       <= zsbp_pkg::HALF_MASK;
			run_hi_q       <= '0;
			last_mean_q    <= '0;
			last_dev_q     <= '0;
			failed_q       <= 1'b0;
			seg_len_q      <= '0;
			pidx_q         <= '0;
			walk_addr_q    <= '0;
			walk_left_q    <= '0;
			rd_pend_s1     <= 1'b0;
			res_status_q   <= 1'b0;
			res_mean_q     <= '0;
			res_dev_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					zsbp_pkg::REG_TRACE_SAMPLES:    trace_q    <= cfg_data;
					zsbp_pkg::REG_BASELINE_SAMPLES: baseline_q <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			rd_pend_s1 <= walk_issue;

			case (state_q)
				zsbp_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.record_start) begin
							offset_q     <= '0;
							words_left_q <= '0;
							prev_end_q   <= zsbp_pkg::OFFSET_MAX;
							seg_cnt_q    <= '0;
							last_mean_q  <= '0;
							last_dev_q   <= '0;
							failed_q     <= 1'b0;
							seg_len_q    <= '0;
							run_sum_q    <= '0;
							run_lo_q     <= zsbp_pkg::HALF_MASK;
							run_hi_q     <= '0;
						end else if (words_left_q != '0) begin
							if (in_base) begin
								run_sum_q <= sum_next;
								run_lo_q  <= lo_next;
								run_hi_q  <= hi_next;
							end
							pidx_q       <= pidx_q + 1'b1;
							words_left_q <= words_left_q - 1'b1;
							if (words_left_q == CTW'(1)) begin
								state_q <= zsbp_pkg::ST_FIN;
							end
						end else if (offset_q < trace_q) begin
							if (!item.data_word[zsbp_pkg::GOOD_BIT]) begin
								offset_q <= skip_sat;
							end else begin
								seg_len_q    <= len_ctl;
								words_left_q <= count;
								pidx_q       <= '0;
								run_sum_q    <= '0;
								run_lo_q     <= zsbp_pkg::HALF_MASK;
								run_hi_q     <= '0;
								if (count == '0) begin
									state_q <= zsbp_pkg::ST_FIN;
								end
							end
						end
					end
				end
				zsbp_pkg::ST_FIN: begin
					res_status_q <= 1'b0;
					res_mean_q   <= '0;
					res_dev_q    <= '0;
					if (failed_q) begin
						res_status_q <= 1'b1;
						state_q      <= zsbp_pkg::ST_DONE;
					end else if ((seg_cnt_q != 2'd0) && (offset_q == prev_end_q)) begin
						res_mean_q <= last_mean_q;
						res_dev_q  <= last_dev_q;
						state_q    <= zsbp_pkg::ST_DONE;
					end else if (seg_len_q < n_ext) begin
						res_status_q <= 1'b1;
						state_q      <= zsbp_pkg::ST_DONE;
					end else if ((seg_len_q < n2_ext) && (end_sat < trace_q)) begin
						if (seg_cnt_q == 2'd0) begin
							// short first segment: baseline from its last n samples
							run_sum_q   <= '0;
							run_lo_q    <= zsbp_pkg::HALF_MASK;
							run_hi_q    <= '0;
							walk_addr_q <= walk_first[AW-1:0];
							walk_left_q <= n_eff >> 1;
							state_q     <= zsbp_pkg::ST_WALK;
						end else begin
							res_status_q <= 1'b1;
							state_q      <= zsbp_pkg::ST_DONE;
						end
					end else begin
						state_q <= zsbp_pkg::ST_DIV;
					end
				end
				zsbp_pkg::ST_WALK: begin
					if (walk_issue) begin
						walk_addr_q <= walk_addr_q + 1'b1;
						walk_left_q <= walk_left_q - 1'b1;
					end
					if (rd_pend_s1) begin
						run_sum_q <= sum_next;
						run_lo_q  <= lo_next;
						run_hi_q  <= hi_next;
					end
					if (stats_start) begin
						state_q <= zsbp_pkg::ST_DIV;
					end
				end
				zsbp_pkg::ST_DIV: begin
					if (stats_done) begin
						res_mean_q <= stats_mean;
						res_dev_q  <= stats_dev;
						state_q    <= zsbp_pkg::ST_DONE;
					end
				end
				zsbp_pkg::ST_DONE: begin
					if (load_out) begin
						result_valid_q <= 1'b1;
						result_q.segment_offset     <= offset_q;
						result_q.segment_length     <= seg_len_q;
						result_q.baseline_mean      <= res_mean_q;
						result_q.baseline_deviation <= res_dev_q;
						result_q.status             <= res_status_q;
						last_mean_q <= res_mean_q;
						last_dev_q  <= res_dev_q;
						prev_end_q  <= end_sat;
						offset_q    <= end_sat;
						if (seg_cnt_q != 2'd3) begin
							seg_cnt_q <= seg_cnt_q + 1'b1;
						end
						if (res_status_q) begin
							failed_q <= 1'b1;
						end
						run_sum_q <= '0;
						run_lo_q  <= zsbp_pkg::HALF_MASK;
						run_hi_q  <= '0;
						state_q   <= zsbp_pkg::ST_IDLE;
					end
				end
				default: state_q <= zsbp_pkg::ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != zsbp_pkg::ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_start_place: assert property (@(posedge clk) disable iff (!arst_n)
		stats_start |-> (state_q == zsbp_pkg::ST_FIN || state_q == zsbp_pkg::ST_WALK))
		else $error("divider started outside decision or walk");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == zsbp_pkg::ST_WALK))
		else $error("store read returned outside the walk");

	a_segment_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != zsbp_pkg::ST_IDLE) |-> (words_left_q == '0))
		else $error("segment end handling with data words outstanding");

	a_done_returns: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == zsbp_pkg::ST_IDLE && result_valid_q))
		else $error("result load did not return to idle");

endmodule

### hw/rtl/zsbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zsbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/zsbp_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbp_stats
// Baseline mean by restoring division (one quotient bit per cycle), then the
// deviation of min and max from the truncated mean.
// ----------------------------------------------------------------------------
module zsbp_stats #(
	parameter int N_W   = 7,
	parameter int SUM_W = 23
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SUM_W-1:0]        sum,
	input  logic [zsbp_pkg::SMP_W-1:0] lo,
	input  logic [zsbp_pkg::SMP_W-1:0] hi,
	input  logic [N_W-1:0]          n,
	output logic                    done,
	output logic [zsbp_pkg::Q_W-1:0] mean,
	output logic [zsbp_pkg::Q_W-1:0] dev
);

	localparam int DW  = SUM_W + 8;
	localparam int CW  = $clog2(DW + 1);
	localparam int QW  = zsbp_pkg::Q_W;

	logic          busy_q, calc_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [N_W-1:0] rem_q, n_q;
	logic [DW-1:0] quo_q;
	logic [zsbp_pkg::SMP_W-1:0] lo_q, hi_q;
	logic [QW-1:0] mean_q, dev_q;

	logic [N_W:0]  trial;
	logic          qbit;
	logic [QW-1:0] m, h, l, dh, dl;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		qbit  = (trial >= {1'b0, n_q});
		m  = quo_q[QW-1:0];
		h  = {hi_q, 8'd0};
		l  = {lo_q, 8'd0};
		dh = (h > m) ? h - m : m - h;
		dl = (l > m) ? l - m : m - l;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			calc_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					calc_q <= 1'b1;
				end
			end else if (calc_q) begin
				calc_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {sum, 8'd0};
			rem_q <= '0;
			n_q   <= n;
			lo_q  <= lo;
			hi_q  <= hi;
		end else if (busy_q) begin
			rem_q <= qbit ? N_W'(trial - {1'b0, n_q}) : trial[N_W-1:0];
			quo_q <= {quo_q[DW-2:0], qbit};
		end
		if (calc_q) begin
			mean_q <= m;
			dev_q  <= (dh > dl) ? dh : dl;
		end
	end

	assign done = done_q;
	assign mean = mean_q;
	assign dev  = dev_q;

endmodule
